@@ design/pwmtuc_pkg.sv @@
package pwmtuc_pkg;

   localparam int OP_BITS        = 2;
   localparam int DUTY_BITS      = 7;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [OP_BITS-1:0]        op_type;
   typedef logic [DUTY_BITS-1:0]      duty_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam op_type OP_TICK  = 2'd0;
   localparam op_type OP_DUTY  = 2'd1;
   localparam op_type OP_FORCE = 2'd2;
   localparam op_type OP_ACK   = 2'd3;

   localparam csr_index_type CSR_PRESCALE = 3'd0;
   localparam csr_index_type CSR_TOP      = 3'd1;
   localparam csr_index_type CSR_PRELOAD  = 3'd2;
   localparam csr_index_type CSR_IRQ      = 3'd3;
   localparam csr_index_type CSR_ENABLE   = 3'd4;

   localparam int       PERCENT_FULL = 100;
   localparam duty_type PERCENT_MAX  = 7'd100;
   localparam int       TOP_RESET    = 999;

endpackage

@@ design/pwmtuc_if.sv @@
interface pwmtuc_req_if;
   logic                 valid;
   logic                 ready;
   pwmtuc_pkg::op_type   op;
   pwmtuc_pkg::duty_type duty_percent;

   modport source (output valid, output op, output duty_percent, input ready);
   modport sink   (input valid, input op, input duty_percent, output ready);
endinterface

interface pwmtuc_rsp_if #(
   parameter int COUNT_BITS   = 16,
   parameter int ELAPSED_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic                    pwm_level;
   logic [COUNT_BITS-1:0]   count_now;
   logic                    update_flag;
   logic                    update_pulse;
   logic [ELAPSED_BITS-1:0] elapsed_updates;
   logic [COUNT_BITS:0]     compare_now;
   logic                    bad_argument;

   modport source (
      output valid, output pwm_level, output count_now, output update_flag,
      output update_pulse, output elapsed_updates, output compare_now,
      output bad_argument, input ready
   );
   modport sink (
      input valid, input pwm_level, input count_now, input update_flag,
      input update_pulse, input elapsed_updates, input compare_now,
      input bad_argument, output ready
   );
endinterface

@@ design/pwm_timer_with_update_count_core.sv @@
// Edge-aligned up-counting timer with prescaler and one PWM channel (mode 1). Each beat on
// req is one operation (tick, duty-percent write, forced update, flag acknowledge) and gives
// exactly one beat on rsp holding the state after that operation. An operation is accepted
// every cycle when rsp keeps up; its result goes from the input register into the rsp register
// once rsp has room. duty_percent * (period_top + 1) is formed ahead of the input register, and
// the update stage between the input and result registers divides that product by 100 with
// a constant reciprocal multiply and advances the prescaler, counter, compare and elapsed
// registers. While rsp is held off, one result and one operation wait and req stalls.
// Registers on the csr port:
// 0 prescale_divider, 1 period_top, 2 compare_preload_on, 3 update_irq_on, 4 count_enable;
// other indexes are ignored. Write them only while no operation is in flight.
module pwm_timer_with_update_count_core #(
   parameter int COUNT_BITS   = 16,
   parameter int ELAPSED_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   pwmtuc_req_if.sink                        req,
   pwmtuc_rsp_if.source                      rsp,
   input  logic                              csr_we,
   input  pwmtuc_pkg::csr_index_type         csr_index,
   input  logic [COUNT_BITS-1:0]             csr_wdata
);

   localparam int CMP_BITS  = COUNT_BITS + 1;
   localparam int PROD_BITS = pwmtuc_pkg::DUTY_BITS + CMP_BITS;
   localparam int DIV_SHIFT = PROD_BITS + $clog2(pwmtuc_pkg::PERCENT_FULL);
   localparam logic [63:0] DIV_MAGIC_WIDE =
      ((64'd1 << DIV_SHIFT) + 64'(pwmtuc_pkg::PERCENT_FULL) - 64'd1)
      / 64'(pwmtuc_pkg::PERCENT_FULL);
   localparam logic [PROD_BITS:0] DIV_MAGIC = DIV_MAGIC_WIDE[PROD_BITS:0];

   // configuration
   logic [COUNT_BITS-1:0] prescale_divider_ff;
   logic [COUNT_BITS-1:0] period_top_ff;
   logic                  preload_on_ff;
   logic                  irq_on_ff;
   logic                  count_enable_ff;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   pwmtuc_pkg::op_type    s1_op_ff;
   logic                  s1_bad_ff;
   logic [PROD_BITS-1:0]  s1_prod_ff;

   // timer state
   logic [COUNT_BITS-1:0]   prescale_count_ff, prescale_count_in;
   logic [COUNT_BITS-1:0]   main_count_ff, main_count_in;
   logic [CMP_BITS-1:0]     active_compare_ff, active_compare_in;
   logic [CMP_BITS-1:0]     pending_compare_ff, pending_compare_in;
   logic                    overflow_flag_ff, overflow_flag_in;
   logic [ELAPSED_BITS-1:0] elapsed_count_ff, elapsed_count_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_pwm_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_flag_ff;
   logic                    rsp_pulse_ff;
   logic [ELAPSED_BITS-1:0] rsp_elapsed_ff;
   logic [CMP_BITS-1:0]     rsp_compare_ff;
   logic                    rsp_bad_ff;

   logic                    req_accept;
   logic                    s2_room;
   logic                    s2_go;
   logic                    pulse;
   logic [CMP_BITS-1:0]     top_plus_one;
   logic [PROD_BITS-1:0]    req_prod;
   logic [2*PROD_BITS:0]    div_full;
   logic [CMP_BITS-1:0]     duty_compare;

   assign s2_room    = !rsp_valid_ff || rsp.ready;
   assign s2_go      = s1_valid_ff && s2_room;
   assign req.ready  = !s1_valid_ff || s2_room;
   assign req_accept = req.valid && req.ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s2_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_go ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // duty product at acceptance
   assign top_plus_one = {1'b0, period_top_ff} + CMP_BITS'(1);
   assign req_prod     = {{CMP_BITS{1'b0}}, req.duty_percent}
                       * {{pwmtuc_pkg::DUTY_BITS{1'b0}}, top_plus_one};

   // divide by 100 through reciprocal
   assign div_full     = {{(PROD_BITS+1){1'b0}}, s1_prod_ff} * {{PROD_BITS{1'b0}}, DIV_MAGIC};
   assign duty_compare = div_full[DIV_SHIFT +: CMP_BITS];

   always_comb begin
      prescale_count_in  = prescale_count_ff;
      main_count_in      = main_count_ff;
      active_compare_in  = active_compare_ff;
      pending_compare_in = pending_compare_ff;
      overflow_flag_in   = overflow_flag_ff;
      elapsed_count_in   = elapsed_count_ff;
      pulse              = 1'b0;
      if (s2_go) begin
         unique case (s1_op_ff)
            pwmtuc_pkg::OP_TICK: begin
               if (count_enable_ff) begin
                  if (prescale_count_ff < prescale_divider_ff) begin
                     prescale_count_in = prescale_count_ff + COUNT_BITS'(1);
                  end else begin
                     prescale_count_in = '0;
                     if (main_count_ff < period_top_ff) begin
                        main_count_in = main_count_ff + COUNT_BITS'(1);
                     end else begin
                        main_count_in    = '0;
                        overflow_flag_in = 1'b1;
                        pulse            = 1'b1;
                        if (irq_on_ff) begin
                           elapsed_count_in = elapsed_count_ff + ELAPSED_BITS'(1);
                        end
                        if (preload_on_ff) begin
                           active_compare_in = pending_compare_ff;
                        end
                     end
                  end
               end
            end
            pwmtuc_pkg::OP_DUTY: begin
               if (!s1_bad_ff) begin
                  pending_compare_in = duty_compare;
                  if (!preload_on_ff) begin
                     active_compare_in = duty_compare;
                  end
               end
            end
            pwmtuc_pkg::OP_FORCE: begin
               prescale_count_in = '0;
               main_count_in     = '0;
               active_compare_in = pending_compare_ff;
            end
            pwmtuc_pkg::OP_ACK: begin
               overflow_flag_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_divider_ff <= '0;
         period_top_ff       <= COUNT_BITS'(pwmtuc_pkg::TOP_RESET);
         preload_on_ff       <= 1'b1;
         irq_on_ff           <= 1'b1;
         count_enable_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pwmtuc_pkg::CSR_PRESCALE: prescale_divider_ff <= csr_wdata;
            pwmtuc_pkg::CSR_TOP:      period_top_ff       <= csr_wdata;
            pwmtuc_pkg::CSR_PRELOAD:  preload_on_ff       <= csr_wdata[0];
            pwmtuc_pkg::CSR_IRQ:      irq_on_ff           <= csr_wdata[0];
            pwmtuc_pkg::CSR_ENABLE:   count_enable_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         prescale_count_ff  <= '0;
         main_count_ff      <= '0;
         active_compare_ff  <= '0;
         pending_compare_ff <= '0;
         overflow_flag_ff   <= 1'b0;
         elapsed_count_ff   <= '0;
      end else begin
         s1_valid_ff        <= s1_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         prescale_count_ff  <= prescale_count_in;
         main_count_ff      <= main_count_in;
         active_compare_ff  <= active_compare_in;
         pending_compare_ff <= pending_compare_in;
         overflow_flag_ff   <= overflow_flag_in;
         elapsed_count_ff   <= elapsed_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req.op;
         s1_bad_ff  <= (req.op == pwmtuc_pkg::OP_DUTY)
                       && (req.duty_percent > pwmtuc_pkg::PERCENT_MAX);
         s1_prod_ff <= req_prod;
      end
      if (s2_go) begin
         rsp_pwm_ff     <= {1'b0, main_count_in} < active_compare_in;
         rsp_count_ff   <= main_count_in;
         rsp_flag_ff    <= overflow_flag_in;
         rsp_pulse_ff   <= pulse;
         rsp_elapsed_ff <= elapsed_count_in;
         rsp_compare_ff <= active_compare_in;
         rsp_bad_ff     <= s1_bad_ff;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.pwm_level       = rsp_pwm_ff;
   assign rsp.count_now       = rsp_count_ff;
   assign rsp.update_flag     = rsp_flag_ff;
   assign rsp.update_pulse    = rsp_pulse_ff;
   assign rsp.elapsed_updates = rsp_elapsed_ff;
   assign rsp.compare_now     = rsp_compare_ff;
   assign rsp.bad_argument    = rsp_bad_ff;

endmodule

@@ verif/pwmtuc_timer_checker.sv @@
`timescale 1ns / 1ps

module pwmtuc_timer_checker #(
   parameter int COUNT_BITS   = 16,
   parameter int ELAPSED_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  pwmtuc_pkg::op_type        req_op,
   input  pwmtuc_pkg::duty_type      req_duty_percent,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_pwm_level,
   input  logic [COUNT_BITS-1:0]     rsp_count_now,
   input  logic                      rsp_update_flag,
   input  logic                      rsp_update_pulse,
   input  logic [ELAPSED_BITS-1:0]   rsp_elapsed_updates,
   input  logic [COUNT_BITS:0]       rsp_compare_now,
   input  logic                      rsp_bad_argument,
   input  logic                      csr_we,
   input  pwmtuc_pkg::csr_index_type csr_index,
   input  logic [COUNT_BITS-1:0]     csr_wdata,
   output int                        mismatches,
   output int                        outstanding
);

   typedef struct packed {
      logic                    pwm_level;
      logic [COUNT_BITS-1:0]   count_now;
      logic                    update_flag;
      logic                    update_pulse;
      logic [ELAPSED_BITS-1:0] elapsed_updates;
      logic [COUNT_BITS:0]     compare_now;
      logic                    bad_argument;
   } timer_readout_type;

   logic [COUNT_BITS-1:0]   cfg_prescale;
   logic [COUNT_BITS-1:0]   cfg_top;
   logic                    cfg_preload;
   logic                    cfg_irq;
   logic                    cfg_enable;

   logic [COUNT_BITS-1:0]   prescale_cnt;
   logic [COUNT_BITS-1:0]   main_cnt;
   logic [COUNT_BITS:0]     active_cmp;
   logic [COUNT_BITS:0]     pending_cmp;
   logic                    overflow_flag;
   logic [ELAPSED_BITS-1:0] elapsed_cnt;

   timer_readout_type pending_readouts[$];
   timer_readout_type oldest_readout;
   int                beats_seen;

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned wanted);
      if (mismatches < 100) begin
         $display("%0t rsp beat %0d: %s is 0x%0h, predicted 0x%0h",
                  $time, beats_seen, what, got, wanted);
      end
      mismatches++;
   endtask

   function automatic logic advance_count();
      if (prescale_cnt < cfg_prescale) begin
         prescale_cnt = prescale_cnt + 1'b1;
         return 1'b0;
      end
      prescale_cnt = '0;
      if (main_cnt < cfg_top) begin
         main_cnt = main_cnt + 1'b1;
         return 1'b0;
      end
      // also taken when the top was lowered below the running count
      main_cnt      = '0;
      overflow_flag = 1'b1;
      if (cfg_irq) elapsed_cnt = elapsed_cnt + 1'b1;
      if (cfg_preload) active_cmp = pending_cmp;
      return 1'b1;
   endfunction

   function automatic timer_readout_type step_timer(pwmtuc_pkg::op_type op,
                                                    pwmtuc_pkg::duty_type duty);
      timer_readout_type                         r;
      logic [COUNT_BITS+pwmtuc_pkg::DUTY_BITS:0] product;
      r = '0;
      case (op)
         pwmtuc_pkg::OP_TICK: begin
            if (cfg_enable) r.update_pulse = advance_count();
         end
         pwmtuc_pkg::OP_DUTY: begin
            if (duty > pwmtuc_pkg::PERCENT_MAX) begin
               r.bad_argument = 1'b1;
            end else begin
               product     = duty * (cfg_top + 1'b1);
               pending_cmp = (COUNT_BITS+1)'(product / pwmtuc_pkg::PERCENT_FULL);
               if (!cfg_preload) active_cmp = pending_cmp;
            end
         end
         pwmtuc_pkg::OP_FORCE: begin
            prescale_cnt = '0;
            main_cnt     = '0;
            active_cmp   = pending_cmp;
         end
         pwmtuc_pkg::OP_ACK: begin
            overflow_flag = 1'b0;
         end
         default: ;
      endcase
      r.pwm_level       = (main_cnt < active_cmp);
      r.count_now       = main_cnt;
      r.update_flag     = overflow_flag;
      r.elapsed_updates = elapsed_cnt;
      r.compare_now     = active_cmp;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_prescale  = '0;
         cfg_top       = COUNT_BITS'(pwmtuc_pkg::TOP_RESET);
         cfg_preload   = 1'b1;
         cfg_irq       = 1'b1;
         cfg_enable    = 1'b0;
         prescale_cnt  = '0;
         main_cnt      = '0;
         active_cmp    = '0;
         pending_cmp   = '0;
         overflow_flag = 1'b0;
         elapsed_cnt   = '0;
         pending_readouts.delete();
         mismatches    = 0;
         beats_seen    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               pwmtuc_pkg::CSR_PRESCALE: cfg_prescale = csr_wdata;
               pwmtuc_pkg::CSR_TOP:      cfg_top      = csr_wdata;
               pwmtuc_pkg::CSR_PRELOAD:  cfg_preload  = csr_wdata[0];
               pwmtuc_pkg::CSR_IRQ:      cfg_irq      = csr_wdata[0];
               pwmtuc_pkg::CSR_ENABLE:   cfg_enable   = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_readouts.size() == 0) begin
               report_mismatch("beat with nothing pending", 1, 0);
            end else begin
               oldest_readout = pending_readouts.pop_front();
               if (rsp_pwm_level !== oldest_readout.pwm_level)
                  report_mismatch("pwm_level", rsp_pwm_level, oldest_readout.pwm_level);
               if (rsp_count_now !== oldest_readout.count_now)
                  report_mismatch("count_now", rsp_count_now, oldest_readout.count_now);
               if (rsp_update_flag !== oldest_readout.update_flag)
                  report_mismatch("update_flag", rsp_update_flag, oldest_readout.update_flag);
               if (rsp_update_pulse !== oldest_readout.update_pulse)
                  report_mismatch("update_pulse", rsp_update_pulse,
                                  oldest_readout.update_pulse);
               if (rsp_elapsed_updates !== oldest_readout.elapsed_updates)
                  report_mismatch("elapsed_updates", rsp_elapsed_updates,
                                  oldest_readout.elapsed_updates);
               if (rsp_compare_now !== oldest_readout.compare_now)
                  report_mismatch("compare_now", rsp_compare_now, oldest_readout.compare_now);
               if (rsp_bad_argument !== oldest_readout.bad_argument)
                  report_mismatch("bad_argument", rsp_bad_argument,
                                  oldest_readout.bad_argument);
            end
            beats_seen++;
         end
         if (req_valid && req_ready) begin
            pending_readouts.push_back(step_timer(req_op, req_duty_percent));
         end
      end
      outstanding = pending_readouts.size();
   end

endmodule

@@ verif/tb_pwm_timer_with_update_count_core.sv @@
`timescale 1ns / 1ps

module tb_pwm_timer_with_update_count_core;

   localparam int COUNT_BITS   = 16;
   localparam int ELAPSED_BITS = 32;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;
   localparam int HOLD_CYCLES  = 300;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   pwmtuc_pkg::csr_index_type csr_index;
   logic [COUNT_BITS-1:0]     csr_wdata;
   int                        mismatches;
   int                        outstanding;
   int                        send_idle_pct = 0;
   int                        recv_idle_pct = 0;
   int                        hold_requests = 0;

   pwmtuc_req_if req_ch ();
   pwmtuc_rsp_if #(.COUNT_BITS(COUNT_BITS), .ELAPSED_BITS(ELAPSED_BITS)) rsp_ch ();

   pwm_timer_with_update_count_core #(
      .COUNT_BITS   (COUNT_BITS),
      .ELAPSED_BITS (ELAPSED_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pwmtuc_timer_checker #(
      .COUNT_BITS   (COUNT_BITS),
      .ELAPSED_BITS (ELAPSED_BITS)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_op              (req_ch.op),
      .req_duty_percent    (req_ch.duty_percent),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_pwm_level       (rsp_ch.pwm_level),
      .rsp_count_now       (rsp_ch.count_now),
      .rsp_update_flag     (rsp_ch.update_flag),
      .rsp_update_pulse    (rsp_ch.update_pulse),
      .rsp_elapsed_updates (rsp_ch.elapsed_updates),
      .rsp_compare_now     (rsp_ch.compare_now),
      .rsp_bad_argument    (rsp_ch.bad_argument),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .outstanding         (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : rsp_ready_drive
      int hold_left;
      int holds_done;
      hold_left    = 0;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_op(pwmtuc_pkg::op_type op, pwmtuc_pkg::duty_type duty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.duty_percent <= duty;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_random_op();
      int                   pick;
      pwmtuc_pkg::op_type   op;
      pwmtuc_pkg::duty_type duty;
      pick = $urandom_range(99);
      if (pick < 68) begin
         op = pwmtuc_pkg::OP_TICK;
      end else if (pick < 82) begin
         op = pwmtuc_pkg::OP_DUTY;
      end else if (pick < 88) begin
         op = pwmtuc_pkg::OP_FORCE;
      end else begin
         op = pwmtuc_pkg::OP_ACK;
      end
      if ($urandom_range(4) == 0) begin
         duty = pwmtuc_pkg::duty_type'($urandom_range((1 << pwmtuc_pkg::DUTY_BITS) - 1,
                                                      int'(pwmtuc_pkg::PERCENT_MAX) + 1));
      end else begin
         duty = pwmtuc_pkg::duty_type'($urandom_range(pwmtuc_pkg::PERCENT_FULL));
      end
      send_op(op, duty);
   endtask

   // lets every beat in flight come back before the block is touched
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic put_csr(pwmtuc_pkg::csr_index_type idx, logic [COUNT_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(logic [COUNT_BITS-1:0] prescale, logic [COUNT_BITS-1:0] top,
                            logic preload, logic irq, logic enable);
      logic [COUNT_BITS-1:0] noise;
      wait_drained();
      put_csr(pwmtuc_pkg::CSR_PRESCALE, prescale);
      put_csr(pwmtuc_pkg::CSR_TOP, top);
      noise = COUNT_BITS'($urandom);
      put_csr(pwmtuc_pkg::CSR_PRELOAD, {noise[COUNT_BITS-1:1], preload});
      noise = COUNT_BITS'($urandom);
      put_csr(pwmtuc_pkg::CSR_IRQ, {noise[COUNT_BITS-1:1], irq});
      noise = COUNT_BITS'($urandom);
      put_csr(pwmtuc_pkg::CSR_ENABLE, {noise[COUNT_BITS-1:1], enable});
      // unmapped index, must be ignored
      put_csr(pwmtuc_pkg::csr_index_type'($urandom_range((1 << pwmtuc_pkg::CSR_INDEX_BITS) - 1,
                                                         int'(pwmtuc_pkg::CSR_ENABLE) + 1)),
              COUNT_BITS'($urandom));
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int p;
      int i;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = pwmtuc_pkg::CSR_PRESCALE;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.op           = pwmtuc_pkg::OP_TICK;
      req_ch.duty_percent = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 66;

      // reset settings: counter stopped, preload on
      send_op(pwmtuc_pkg::OP_TICK, 7'd0);
      send_op(pwmtuc_pkg::OP_DUTY, 7'd0);
      send_op(pwmtuc_pkg::OP_DUTY, pwmtuc_pkg::PERCENT_MAX);
      send_op(pwmtuc_pkg::OP_DUTY, pwmtuc_pkg::PERCENT_MAX + 1'b1);
      send_op(pwmtuc_pkg::OP_DUTY, 7'd127);
      send_op(pwmtuc_pkg::OP_FORCE, 7'd0);
      send_op(pwmtuc_pkg::OP_ACK, 7'd0);

      configure(16'd0, 16'd20, 1'b0, 1'b1, 1'b1);
      send_op(pwmtuc_pkg::OP_DUTY, 7'd50);
      repeat (8) send_op(pwmtuc_pkg::OP_TICK, 7'd0);

      // top drops below the running count
      configure(16'd0, 16'd2, 1'b0, 1'b1, 1'b1);
      send_op(pwmtuc_pkg::OP_TICK, 7'd0);
      send_op(pwmtuc_pkg::OP_ACK, 7'd0);
      repeat (3) send_op(pwmtuc_pkg::OP_TICK, 7'd0);

      configure(16'd0, 16'd2, 1'b1, 1'b0, 1'b1);
      send_op(pwmtuc_pkg::OP_DUTY, 7'd25);
      repeat (3) send_op(pwmtuc_pkg::OP_TICK, 7'd0);

      for (p = 0; p < PHASES; p++) begin
         if (p == 4) begin
            send_idle_pct = 66;
            recv_idle_pct = 35;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (p)
            0: configure('0, '0, 1'b1, 1'b1, 1'b1);
            1: configure('1, '1, 1'b0, 1'b0, 1'b1);
            2: configure('0, '1, 1'b1, 1'b0, 1'b1);
            3: configure(16'd1, 16'd4, 1'b0, 1'b1, 1'b0);
            default: begin
               configure(($urandom_range(9) == 0) ? COUNT_BITS'($urandom)
                                                  : COUNT_BITS'($urandom_range(3)),
                         ($urandom_range(9) == 0) ? COUNT_BITS'($urandom)
                                                  : COUNT_BITS'($urandom_range(40)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         $urandom_range(7) != 0);
            end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 9 && i == 20) hold_requests++;
            send_random_op();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/pwmtuc_pkg.sv
design/pwmtuc_if.sv
design/pwm_timer_with_update_count_core.sv
verif/pwmtuc_timer_checker.sv
verif/tb_pwm_timer_with_update_count_core.sv
